/* sv/csqf_pkg.sv */
// Shared types, constants and helpers for the cascaded SOGI quadrature filter.
// Holds the fixed-point formats, micro-op codes, control word layout and the
// microcode ROM. No dependencies.
package csqf_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int STATE_W      = 32;
    localparam int SAMPLE_FRAC  = SAMPLE_W - 1;
    localparam int STATE_FRAC   = STATE_W - 4;
    localparam int SAMPLE_SHIFT = STATE_FRAC - SAMPLE_FRAC;
    localparam int KP_W         = 16;
    localparam int KP_FRAC      = 14;
    localparam int G_W          = 24;
    localparam int G_FRAC       = 24;
    localparam int MUL_B_W      = G_W + 1;
    localparam int PROD_W       = STATE_W + MUL_B_W;
    localparam int OUT_PRE_W    = STATE_W - SAMPLE_SHIFT;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STAGE2_EN    = CFG_IDX_W'(2);
    localparam logic [KP_W-1:0] DAMPING_GAIN_RST = KP_W'(23167);
    localparam logic [G_W-1:0]  STEP_GAIN_RST    = G_W'(131761);

    // microprogram: eight steps per stage, then the output step
    localparam int STAGE_STEPS = 8;
    localparam int UCODE_LEN   = 2 * STAGE_STEPS + 1;
    localparam int PC_W        = $clog2(UCODE_LEN);
    localparam logic [PC_W-1:0] OUT_STEP = PC_W'(2 * STAGE_STEPS);

    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_ERR,       // t = sat(x - A)
        UOP_MUL_KP,    // p = t * kp
        UOP_SCALE_KP,  // t = sat(p >>> 14)
        UOP_SUB_B,     // t = sat(t - B)
        UOP_MUL_U,     // p = t * g
        UOP_UPD_A,     // A = sat(A + d + PA), PA = d
        UOP_MUL_A,     // p = A * g
        UOP_UPD_B,     // B = sat(B + d + PB), PB = d
        UOP_OUT        // load result registers
    } uop_t;

    typedef struct packed {
        uop_t            uop;
        logic            stage;
        logic            skip_single;  // jump to target when stage two is off
        logic [PC_W-1:0] target;
        logic            last;
    } ucode_t;

    typedef struct packed {
        uop_t uop;
        logic stage;
        logic sample_load;
    } dp_ctrl_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        w.uop         = UOP_IDLE;
        w.stage       = (addr >= PC_W'(STAGE_STEPS)) && (addr < OUT_STEP);
        w.skip_single = 1'b0;
        w.target      = OUT_STEP;
        w.last        = 1'b0;
        case (addr)
            PC_W'(0), PC_W'(8):  w.uop = UOP_ERR;
            PC_W'(1), PC_W'(9):  w.uop = UOP_MUL_KP;
            PC_W'(2), PC_W'(10): w.uop = UOP_SCALE_KP;
            PC_W'(3), PC_W'(11): w.uop = UOP_SUB_B;
            PC_W'(4), PC_W'(12): w.uop = UOP_MUL_U;
            PC_W'(5), PC_W'(13): w.uop = UOP_UPD_A;
            PC_W'(6), PC_W'(14): w.uop = UOP_MUL_A;
            PC_W'(7): begin
                w.uop         = UOP_UPD_B;
                w.skip_single = 1'b1;
            end
            PC_W'(15): w.uop = UOP_UPD_B;
            OUT_STEP: begin
                w.uop  = UOP_OUT;
                w.last = 1'b1;
            end
            default: w.uop = UOP_IDLE;
        endcase
        return w;
    endfunction

    // saturate a wide signed value to the state range
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [PROD_W-1:0] v);
        logic [PROD_W-STATE_W:0] hi;
        hi = v[PROD_W-1:STATE_W-1];
        if ((&hi) || !(|hi))
            return v[STATE_W-1:0];
        else if (v[PROD_W-1])
            return STATE_MIN;
        else
            return STATE_MAX;
    endfunction

    // state format to sample format: floor shift then saturate
    function automatic logic signed [SAMPLE_W-1:0] state_to_sample(
        input logic signed [STATE_W-1:0] v);
        logic [OUT_PRE_W-1:0]          t;
        logic [OUT_PRE_W-SAMPLE_W:0]   hi;
        t  = v[STATE_W-1:SAMPLE_SHIFT];
        hi = t[OUT_PRE_W-1:SAMPLE_W-1];
        if ((&hi) || !(|hi))
            return t[SAMPLE_W-1:0];
        else if (t[OUT_PRE_W-1])
            return SAMPLE_MIN;
        else
            return SAMPLE_MAX;
    endfunction

endpackage

/* sv/csqf_useq.sv */
// Microcode sequencer: step counter, ROM fetch, conditional skip of stage two
// and input handshake. Depends on csqf_pkg.
module csqf_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              stage2_en,
    input  logic              out_free,
    output csqf_pkg::dp_ctrl_t ctrl
);
    import csqf_pkg::*;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          word;

    assign s_ready = !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    always_comb begin
        word             = ucode_rom(pc_reg);
        busy_next        = busy_reg;
        pc_next          = pc_reg;
        ctrl.uop         = UOP_IDLE;
        ctrl.stage       = word.stage;
        ctrl.sample_load = s_valid && !busy_reg;
        if (!busy_reg) begin
            if (s_valid) begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end else if (word.last) begin
            // hold on the output step until the result register is free
            if (out_free) begin
                ctrl.uop  = word.uop;
                busy_next = 1'b0;
            end
        end else begin
            ctrl.uop = word.uop;
            if (word.skip_single && !stage2_en)
                pc_next = word.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg < PC_W'(UCODE_LEN)))
        else $error("step counter outside microprogram");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.uop == UOP_OUT) |-> out_free)
        else $error("result loaded over an untaken transaction");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && (pc_reg == '0)))
        else $error("accepted transaction did not start the program");

endmodule

/* sv/csqf_datapath.sv */
// Datapath: filter state, shared multiplier, saturating adder and result
// registers, driven by one control word per cycle. Depends on csqf_pkg.
module csqf_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  csqf_pkg::dp_ctrl_t                    ctrl,
    input  logic signed [csqf_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [csqf_pkg::KP_W-1:0]             damping_gain,
    input  logic [csqf_pkg::G_W-1:0]              step_gain,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]  alpha_out,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]  beta_out,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]  alpha2_out,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]  beta2_out
);
    import csqf_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [STATE_W-1:0]  alpha_reg, beta_reg, alpha_prev_reg, beta_prev_reg;
    logic signed [STATE_W-1:0]  alpha2_reg, beta2_reg, alpha2_prev_reg, beta2_prev_reg;
    logic signed [STATE_W-1:0]  tmp_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] alpha_out_reg, beta_out_reg, alpha2_out_reg, beta2_out_reg;

    logic signed [STATE_W-1:0]  x_val, sel_a, sel_b, sel_pa, sel_pb, d_val;
    logic signed [STATE_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [STATE_W-1:0]  tmp_next, acc_next;
    logic signed [PROD_W-1:0]   prod_next;

    always_comb begin
        // stage two takes the fresh first-stage alpha as its input
        x_val  = ctrl.stage ? alpha_reg
                            : {{(STATE_W-SAMPLE_W-SAMPLE_SHIFT){sample_reg[SAMPLE_W-1]}},
                               sample_reg, {SAMPLE_SHIFT{1'b0}}};
        sel_a  = ctrl.stage ? alpha2_reg      : alpha_reg;
        sel_b  = ctrl.stage ? beta2_reg       : beta_reg;
        sel_pa = ctrl.stage ? alpha2_prev_reg : alpha_prev_reg;
        sel_pb = ctrl.stage ? beta2_prev_reg  : beta_prev_reg;
        // |u|,|A| < 2^31 and g < 1, so the gain product always fits the state
        d_val  = prod_reg[G_FRAC +: STATE_W];

        mul_a = (ctrl.uop == UOP_MUL_A) ? sel_a : tmp_reg;
        mul_b = (ctrl.uop == UOP_MUL_KP) ? $signed({{(MUL_B_W-KP_W){1'b0}}, damping_gain})
                                         : $signed({1'b0, step_gain});
        prod_next = mul_a * mul_b;

        tmp_next = tmp_reg;
        acc_next = sel_a;
        case (ctrl.uop)
            UOP_ERR:      tmp_next = sat_state(PROD_W'(x_val) - PROD_W'(sel_a));
            UOP_SCALE_KP: tmp_next = sat_state(prod_reg >>> KP_FRAC);
            UOP_SUB_B:    tmp_next = sat_state(PROD_W'(tmp_reg) - PROD_W'(sel_b));
            UOP_UPD_A:    acc_next = sat_state(PROD_W'(sel_a) + PROD_W'(d_val)
                                               + PROD_W'(sel_pa));
            UOP_UPD_B:    acc_next = sat_state(PROD_W'(sel_b) + PROD_W'(d_val)
                                               + PROD_W'(sel_pb));
            default:      tmp_next = tmp_reg;
        endcase
    end

    // working registers carry no reset
    always_ff @(posedge aclk) begin
        if (ctrl.sample_load)
            sample_reg <= sample_in;
        tmp_reg <= tmp_next;
        if (ctrl.uop == UOP_MUL_KP || ctrl.uop == UOP_MUL_U || ctrl.uop == UOP_MUL_A)
            prod_reg <= prod_next;
        if (ctrl.uop == UOP_OUT) begin
            alpha_out_reg  <= state_to_sample(alpha_reg);
            beta_out_reg   <= state_to_sample(beta_reg);
            alpha2_out_reg <= state_to_sample(alpha2_reg);
            beta2_out_reg  <= state_to_sample(beta2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg       <= '0;
            beta_reg        <= '0;
            alpha_prev_reg  <= '0;
            beta_prev_reg   <= '0;
            alpha2_reg      <= '0;
            beta2_reg       <= '0;
            alpha2_prev_reg <= '0;
            beta2_prev_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // a new result may be loaded in the cycle the old one is taken
            if (ctrl.uop == UOP_OUT)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            case (ctrl.uop)
                UOP_UPD_A: begin
                    if (ctrl.stage) begin
                        alpha2_reg      <= acc_next;
                        alpha2_prev_reg <= d_val;
                    end else begin
                        alpha_reg      <= acc_next;
                        alpha_prev_reg <= d_val;
                    end
                end
                UOP_UPD_B: begin
                    if (ctrl.stage) begin
                        beta2_reg      <= acc_next;
                        beta2_prev_reg <= d_val;
                    end else begin
                        beta_reg      <= acc_next;
                        beta_prev_reg <= d_val;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign alpha_out  = alpha_out_reg;
    assign beta_out   = beta_out_reg;
    assign alpha2_out = alpha2_out_reg;
    assign beta2_out  = beta2_out_reg;

endmodule

/* sv/cascaded_sogi_quadrature_filter_unit.sv */
// Cascaded SOGI quadrature filter: one result per sample, microcoded datapath.
// A new sample is taken only after the output step of the previous one, which waits
// until the result register is free; the microprogram has 8 steps per stage on the
// shared multiplier plus one output step.
// Reset (aresetn low, synchronous): filter state cleared, gains to defaults, idle.
// Depends on csqf_pkg, csqf_useq and csqf_datapath.
module cascaded_sogi_quadrature_filter_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [csqf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [csqf_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [csqf_pkg::SAMPLE_W-1:0]     s_sample_in,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]     m_alpha_out,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]     m_beta_out,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]     m_alpha2_out,
    output logic signed [csqf_pkg::SAMPLE_W-1:0]     m_beta2_out
);
    import csqf_pkg::*;

    logic [KP_W-1:0] damping_gain_reg;
    logic [G_W-1:0]  step_gain_reg;
    logic            stage2_en_reg;
    dp_ctrl_t        ctrl;
    logic            out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damping_gain_reg <= DAMPING_GAIN_RST;
            step_gain_reg    <= STEP_GAIN_RST;
            stage2_en_reg    <= 1'b0;
        end else if (cfg_valid) begin
            // unknown indexes are dropped
            case (cfg_index)
                REG_DAMPING_GAIN: damping_gain_reg <= cfg_data[KP_W-1:0];
                REG_STEP_GAIN:    step_gain_reg    <= cfg_data[G_W-1:0];
                REG_STAGE2_EN:    stage2_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid || m_ready;

    csqf_useq u_useq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .stage2_en (stage2_en_reg),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    csqf_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .sample_in    (s_sample_in),
        .damping_gain (damping_gain_reg),
        .step_gain    (step_gain_reg),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .alpha_out    (m_alpha_out),
        .beta_out     (m_beta_out),
        .alpha2_out   (m_alpha2_out),
        .beta2_out    (m_beta2_out)
    );

endmodule

/* tb/cascaded_sogi_quadrature_filter_unit_tb.sv */
// Self-checking testbench for cascaded_sogi_quadrature_filter_unit.
// Bit-exact SOGI predictor, queue-fed sample driver, result monitor and register writes.
// Depends on csqf_pkg and the filter RTL only.
module cascaded_sogi_quadrature_filter_unit_tb;

    localparam int SW    = csqf_pkg::SAMPLE_W;
    localparam int XW    = csqf_pkg::STATE_W;
    localparam int SHIFT = csqf_pkg::SAMPLE_SHIFT;
    localparam int IW    = csqf_pkg::CFG_IDX_W;
    localparam int DW    = csqf_pkg::CFG_DATA_W;
    localparam int KP_FRAC = csqf_pkg::KP_FRAC;
    localparam int G_FRAC  = csqf_pkg::G_FRAC;

    localparam int DRAIN_CYCLES   = 40;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;

    typedef logic [3:0][SW-1:0] filter_out_t;   // 0 alpha, 1 beta, 2 alpha2, 3 beta2

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [IW-1:0]        cfg_index   = '0;
    logic [DW-1:0]        cfg_data    = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic signed [SW-1:0] s_sample_in = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic signed [SW-1:0] m_alpha_out, m_beta_out, m_alpha2_out, m_beta2_out;

    cascaded_sogi_quadrature_filter_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_alpha_out  (m_alpha_out),
        .m_beta_out   (m_beta_out),
        .m_alpha2_out (m_alpha2_out),
        .m_beta2_out  (m_beta2_out)
    );

    always #5 aclk = ~aclk;

    // filter settings as the block should hold them
    logic [15:0] kp_q       = csqf_pkg::DAMPING_GAIN_RST;
    logic [23:0] step_gain_q = csqf_pkg::STEP_GAIN_RST;
    logic        stage2_en_q = 1'b0;

    // integrator state per stage: accumulators and previous increments
    longint sogi_a[2]  = '{0, 0};
    longint sogi_b[2]  = '{0, 0};
    longint sogi_pa[2] = '{0, 0};
    longint sogi_pb[2] = '{0, 0};

    logic signed [SW-1:0] pending_q[$];
    filter_out_t          expected_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int samples_accepted = 0;
    int results_checked  = 0;
    int settings_used    = 0;

    logic rx_hold_go    = 1'b0;
    int   rx_hold_count = 0;
    logic rx_hold_active;

    string field_name[4] = '{"alpha_out", "beta_out", "alpha2_out", "beta2_out"};

    function automatic longint clamp_w(input longint v, input int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint gain_mul(input longint v);
        return clamp_w((v * longint'(step_gain_q)) >>> G_FRAC, XW);
    endfunction

    function automatic void run_sogi(input int st, input longint x);
        longint err, ke, u, d1, d2;
        err = clamp_w(x - sogi_a[st], XW);
        ke  = clamp_w((err * longint'(kp_q)) >>> KP_FRAC, XW);
        u   = clamp_w(ke - sogi_b[st], XW);
        d1  = gain_mul(u);
        sogi_a[st]  = clamp_w(sogi_a[st] + d1 + sogi_pa[st], XW);
        sogi_pa[st] = d1;
        d2  = gain_mul(sogi_a[st]);
        sogi_b[st]  = clamp_w(sogi_b[st] + d2 + sogi_pb[st], XW);
        sogi_pb[st] = d2;
    endfunction

    function automatic logic [SW-1:0] to_sample_fmt(input longint v);
        return SW'(clamp_w(v >>> SHIFT, SW));
    endfunction

    function automatic filter_out_t filter_step(input logic signed [SW-1:0] smp);
        filter_out_t r;
        run_sogi(0, clamp_w(longint'(smp) <<< SHIFT, XW));
        if (stage2_en_q)
            run_sogi(1, sogi_a[0]);
        r[0] = to_sample_fmt(sogi_a[0]);
        r[1] = to_sample_fmt(sogi_b[0]);
        r[2] = to_sample_fmt(sogi_a[1]);
        r[3] = to_sample_fmt(sogi_b[1]);
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_q.push_back(filter_step(s_sample_in));
                samples_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid     <= 1'b1;
                    s_sample_in <= pending_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold, counted here so the sender keeps offering meanwhile
    always @(posedge aclk) begin
        if (rx_hold_go && rx_hold_count < RX_HOLD_CYCLES)
            rx_hold_count <= rx_hold_count + 1;
    end
    assign rx_hold_active = rx_hold_go && (rx_hold_count < RX_HOLD_CYCLES);

    // result monitor
    always @(posedge aclk) begin
        filter_out_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_beta2_out, m_alpha2_out, m_beta_out, m_alpha_out};
                if (expected_q.size() == 0) begin
                    report_error($sformatf("result with nothing outstanding: %h", got));
                end else begin
                    want = expected_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== want[i])
                            report_error($sformatf("result %0d %s expected %0d got %0d",
                                results_checked, field_name[i],
                                $signed(want[i]), $signed(got[i])));
                end
                results_checked++;
            end
            m_ready <= !rx_hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            csqf_pkg::REG_DAMPING_GAIN: kp_q        = data[15:0];
            csqf_pkg::REG_STEP_GAIN:    step_gain_q = data[23:0];
            csqf_pkg::REG_STAGE2_EN:    stage2_en_q = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // upper data bits are junk to check masking; one write to an unused index too
    task automatic set_filter(input logic [15:0] kp, input logic [23:0] g, input logic en);
        logic [DW-1:0] junk;
        junk = DW'($urandom);
        write_reg(csqf_pkg::REG_DAMPING_GAIN, {junk[DW-1:16], kp});
        write_reg(csqf_pkg::REG_STEP_GAIN, g);
        write_reg(csqf_pkg::REG_STAGE2_EN, {junk[DW-1:1], en});
        write_reg(IW'($urandom_range(3, (1 << IW) - 1)), DW'($urandom));
        settings_used++;
        @(negedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    task automatic push_tone(input int n);
        real amp, step, ph;
        int  v;
        amp  = $urandom_range(1, 32767);
        step = 6.283185307 / $urandom_range(8, 200);
        ph   = $urandom_range(0, 6283) / 1000.0;
        for (int i = 0; i < n; i++) begin
            v = int'(amp * $sin(ph + step * i)) + $urandom_range(0, 64) - 32;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            pending_q.push_back(SW'(v));
        end
    endtask

    // mostly tones, some noise bursts and held levels (extremes, zero or random)
    task automatic push_mixed(input int n);
        int len, pick, k;
        logic signed [SW-1:0] lvl;
        k = 0;
        while (k < n) begin
            len = $urandom_range(10, 50);
            if (len > n - k) len = n - k;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                push_tone(len);
            end else if (pick < 9) begin
                repeat (len) pending_q.push_back(SW'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: lvl = 16'sh7fff;
                    1: lvl = -16'sh8000;
                    2: lvl = '0;
                    default: lvl = SW'($urandom);
                endcase
                repeat (len) pending_q.push_back(lvl);
            end
            k += len;
        end
    endtask

    function automatic logic [23:0] pick_gain();
        if ($urandom_range(0, 3) == 0)
            return 24'($urandom);
        return 24'($urandom_range(0, 1 << 19));
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes at reset settings, second stage off
        foreach (pending_q[i]) ;
        pending_q = '{16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
                      -16'sh8000, 16'sh0001, -16'sh0001, 16'sh0000};
        wait_drained();

        // largest gains, second stage on: saturation everywhere
        set_filter(16'hffff, 24'hffffff, 1'b1);
        pending_q = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
                      -16'sh8000, -16'sh8000, 16'sh0000, 16'sh3039};
        wait_drained();

        // back to default gains, no idling
        set_filter(csqf_pkg::DAMPING_GAIN_RST, csqf_pkg::STEP_GAIN_RST, 1'b1);
        set_idling(0);
        push_mixed(200);
        wait_drained();

        set_filter(16'hffff, 24'hffffff, 1'b1);
        set_idling(1);
        push_mixed(150);
        wait_drained();

        // zero gains; second stage off so it holds its state
        set_filter(16'h0000, 24'h000000, 1'b0);
        set_idling(2);
        push_mixed(100);
        wait_drained();

        set_filter(16'($urandom), pick_gain(), 1'b1);
        set_idling(3);
        push_mixed(250);
        wait_drained();

        // back-pressure: output held long enough to stall the input,
        // then the sender waits for every result before carrying on
        set_filter(csqf_pkg::DAMPING_GAIN_RST, pick_gain(), 1'b1);
        set_idling(0);
        push_mixed(80);
        rx_hold_go = 1'b1;
        wait_drained();
        push_mixed(70);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            set_filter(($urandom_range(0, 1) != 0) ? 16'($urandom) : csqf_pkg::DAMPING_GAIN_RST,
                       pick_gain(), 1'($urandom_range(0, 1)));
            set_idling(p);
            push_mixed(140);
            wait_drained();
        end

        $display("Covered %0d samples and %0d results over %0d filter settings,",
                 samples_accepted, results_checked, settings_used);
        $display("with idle, stall and %0d-cycle output hold phases.", RX_HOLD_CYCLES);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors, %0d results outstanding", error_count, expected_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timed out with %0d results outstanding", expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
